>>> rtl/core/sha2_pkg.sv
// ----------------------------------------------------------------------------
// SHA-2 hash package
// Round constants, initial hash values, sequencer states and the SHA-256
// logical functions shared by the hash core.
// ----------------------------------------------------------------------------
package sha2_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } sha2_st_t;

  localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;
  localparam logic [2:0]  PAD_MARK_BYTES = 3'd1;
  localparam logic [2:0]  WORD_BYTES = 3'd4;
  localparam logic [4:0]  BLOCK_WORDS_M1 = 5'd15;
  localparam logic [4:0]  LEN_WORD_POS = 5'd14;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_INDEX_256 = 3'd7;
  localparam logic [2:0]  LAST_INDEX_224 = 3'd6;

  localparam logic [31:0] IV_256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] IV_224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

>>> rtl/core/sha256_sha224_hash.sv
// ----------------------------------------------------------------------------
// SHA-256 / SHA-224 hash core
// Packs a byte stream into 512-bit blocks, runs one compression round per
// cycle, pads the message and returns the digest one word per request.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one request per message word: in_data_word holds
// up to four bytes, first byte in bits 31..24, in_valid_bytes counts them and
// in_last_word ends the message. Short words may appear anywhere; their bytes
// pack as a plain byte stream. A word is taken while in_stall is low. Each
// completed 64-byte block holds the input for 64 rounds and a chaining
// update. After the last word the block pads the message (a marker byte,
// zero words and the two length words, compressing each block it fills)
// and then offers 8 digest words, or 7 in SHA-224 mode, one per cycle on
// the output channel while out_stall is low. While the receiver stalls,
// the current digest word holds; the next message is taken only after the
// final digest word is accepted. cfg_we writes the mode bit, reloads the
// initial values and drops any partial message. Reset selects SHA-256 and
// starts an empty message.
// ----------------------------------------------------------------------------
module sha256_sha224_hash
  import sha2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_mode_224,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_of_digest
);

  sha2_st_t    state_r, state_nxt;
  sha2_st_t    ret_r, ret_nxt;
  logic        mode_r, mode_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] vars_r [8];
  logic [31:0] vars_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [4:0]  wcnt_r, wcnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  acc_n_r, acc_n_nxt;
  logic [63:0] bit_len_r, bit_len_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  logic [2:0]  in_cnt;
  logic [31:0] acc_m;
  logic [31:0] mrg_word;
  logic [2:0]  mrg_cnt;
  logic [31:0] mrg_mask;
  logic [63:0] mrg_cat;
  logic [2:0]  mrg_total;
  logic        push_en;
  logic [31:0] push_word;
  sha2_st_t    after_st;
  logic [31:0] t1, t2, w_new;
  logic [2:0]  last_idx;

  assign in_cnt = (in_valid_bytes > WORD_BYTES) ? WORD_BYTES : in_valid_bytes;
  assign acc_m = acc_r & ~(32'hFFFF_FFFF >> {acc_n_r, 3'b000});
  assign mrg_word = (state_r == ST_MARK) ? PAD_MARK_WORD : in_data_word;
  assign mrg_cnt = (state_r == ST_MARK) ? PAD_MARK_BYTES : in_cnt;
  assign mrg_mask = ~(32'hFFFF_FFFF >> {mrg_cnt, 3'b000});
  assign mrg_cat = {acc_m, 32'h0} | ({mrg_word & mrg_mask, 32'h0} >> {acc_n_r, 3'b000});
  assign mrg_total = {1'b0, acc_n_r} + mrg_cnt;

  assign t1 = vars_r[7] + big_sig1(vars_r[4])
            + ((vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]))
            + ROUND_K[round_r] + w_r[0];
  assign t2 = big_sig0(vars_r[0])
            + ((vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]));
  assign w_new = small_sig1(w_r[14]) + w_r[9] + small_sig0(w_r[1]) + w_r[0];

  assign last_idx = mode_r ? LAST_INDEX_224 : LAST_INDEX_256;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_digest_word = chain_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_of_digest = (oidx_r == last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r <= ST_IDLE;
      mode_r <= 1'b0;
      wcnt_r <= '0;
      acc_n_r <= '0;
      bit_len_r <= '0;
      round_r <= '0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= IV_256[i];
        vars_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      mode_r <= mode_nxt;
      wcnt_r <= wcnt_nxt;
      acc_n_r <= acc_n_nxt;
      bit_len_r <= bit_len_nxt;
      round_r <= round_nxt;
      oidx_r <= oidx_nxt;
      chain_r <= chain_nxt;
      vars_r <= vars_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    w_r <= w_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    mode_nxt = mode_r;
    chain_nxt = chain_r;
    vars_nxt = vars_r;
    w_nxt = w_r;
    wcnt_nxt = wcnt_r;
    acc_nxt = acc_r;
    acc_n_nxt = acc_n_r;
    bit_len_nxt = bit_len_r;
    round_nxt = round_r;
    oidx_nxt = oidx_r;
    push_en = 1'b0;
    push_word = mrg_cat[63:32];
    after_st = state_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          push_en = mrg_total[2];
          acc_nxt = mrg_total[2] ? mrg_cat[31:0] : mrg_cat[63:32];
          acc_n_nxt = mrg_total[1:0];
          bit_len_nxt = bit_len_r + {58'd0, in_cnt, 3'b000};
          after_st = in_last_word ? ST_MARK : ST_IDLE;
        end
      end
      ST_MARK: begin
        push_en = mrg_total[2];
        acc_nxt = mrg_total[2] ? mrg_cat[31:0] : mrg_cat[63:32];
        acc_n_nxt = mrg_total[1:0];
        after_st = ST_ZERO;
      end
      ST_ZERO: begin
        if (wcnt_r == LEN_WORD_POS && acc_n_r == 2'd0) begin
          after_st = ST_LEN_HI;
        end else begin
          push_en = 1'b1;
          push_word = acc_m;
          acc_n_nxt = 2'd0;
          after_st = ST_ZERO;
        end
      end
      ST_LEN_HI: begin
        push_en = 1'b1;
        push_word = bit_len_r[63:32];
        after_st = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        push_en = 1'b1;
        push_word = bit_len_r[31:0];
        oidx_nxt = 3'd0;
        after_st = ST_OUT;
      end
      ST_ROUND: begin
        for (int i = 7; i > 0; i--) begin
          vars_nxt[i] = vars_r[i-1];
        end
        vars_nxt[4] = vars_r[3] + t1;
        vars_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        wcnt_nxt = 5'd0;
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (oidx_r == last_idx) begin
            for (int i = 0; i < 8; i++) begin
              chain_nxt[i] = mode_r ? IV_224[i] : IV_256[i];
            end
            bit_len_nxt = 64'd0;
            state_nxt = ST_IDLE;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (state_r != ST_ROUND && state_r != ST_UPDATE && state_r != ST_OUT) begin
      state_nxt = after_st;
      if (push_en) begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = push_word;
        wcnt_nxt = wcnt_r + 5'd1;
        if (wcnt_r == BLOCK_WORDS_M1) begin
          vars_nxt = chain_r;
          round_nxt = 6'd0;
          ret_nxt = after_st;
          state_nxt = ST_ROUND;
        end
      end
    end

    if (cfg_we) begin
      mode_nxt = cfg_mode_224;
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = cfg_mode_224 ? IV_224[i] : IV_256[i];
      end
      wcnt_nxt = 5'd0;
      acc_n_nxt = 2'd0;
      bit_len_nxt = 64'd0;
    end
  end

  a_round_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> wcnt_r == 5'd16)
    else $error("Compression running without a full block.");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && round_r == LAST_ROUND |=> state_r == ST_UPDATE)
    else $error("Compression did not end after the last round.");

  a_update_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE && !cfg_we |=> wcnt_r == 5'd0)
    else $error("Block buffer not emptied after the chaining update.");

  a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> wcnt_r == 5'd0 && acc_n_r == 2'd0)
    else $error("Digest offered with message bytes still buffered.");

  a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_of_digest |=> state_r == ST_IDLE
      && bit_len_r == 64'd0)
    else $error("Next message not started after the final digest word.");

endmodule
